### rtl/utf8d_pkg.sv
package utf8d_pkg;

   // Byte class boundaries (inclusive upper bounds).
   localparam logic [7:0] AsciiMax = 8'h7F;
   localparam logic [7:0] ContMax  = 8'hBF;
   localparam logic [7:0] Lead2Max = 8'hDF;
   localparam logic [7:0] Lead3Max = 8'hEF;
   localparam logic [7:0] Lead4Max = 8'hF7;

   // Payload masks for continuation and lead bytes.
   localparam logic [7:0] ContMask  = 8'h3F;
   localparam logic [7:0] Lead2Mask = 8'h1F;
   localparam logic [7:0] Lead3Mask = 8'h0F;
   localparam logic [7:0] Lead4Mask = 8'h07;

   localparam int CpWidth = 21;
   localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

   // Result queue geometry.
   localparam int FifoDepth    = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCntWidth = $clog2(FifoDepth + 1);
   localparam int MaxResults   = 2;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               is_replacement;
      logic               last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0]               result_count;
      result_type [MaxResults-1:0] results;
      logic [1:0]               pending_count;
      logic [CpWidth-1:0]       code_accumulator;
   } decode_type;

   function automatic result_type make_result(logic [CpWidth-1:0] cp, logic repl);
      result_type r;
      r.code_point     = cp;
      r.is_replacement = repl;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

endpackage

### rtl/utf8d_decode.sv
// Decodes one byte against the current sequence state: produces up to two
// results and the next state.
module utf8d_decode (
   input  logic [7:0]                     byte_value,
   input  logic                           end_of_text,
   input  logic [1:0]                     pending_count,
   input  logic [utf8d_pkg::CpWidth-1:0]  code_accumulator,
   output utf8d_pkg::decode_type          decode
);

   logic [utf8d_pkg::CpWidth-1:0] shifted_acc;
   utf8d_pkg::result_type         repl;
   utf8d_pkg::result_type         ascii_res;
   logic [1:0]                    cont_left;

   assign shifted_acc = {code_accumulator[utf8d_pkg::CpWidth-7:0],
                         byte_value[5:0] & utf8d_pkg::ContMask[5:0]};
   assign repl        = utf8d_pkg::make_result(utf8d_pkg::ReplacementCp, 1'b1);
   assign ascii_res   = utf8d_pkg::make_result(
                           {{(utf8d_pkg::CpWidth-8){1'b0}}, byte_value}, 1'b0);
   assign cont_left   = pending_count - 2'd1;

   always_comb begin
      decode                  = '0;
      decode.pending_count    = pending_count;
      decode.code_accumulator = code_accumulator;

      priority if (byte_value <= utf8d_pkg::AsciiMax) begin
         // A pending sequence cut off by ASCII yields a replacement first.
         if (pending_count != 2'd0) begin
            decode.results[0]   = repl;
            decode.results[1]   = ascii_res;
            decode.result_count = 2'd2;
         end else begin
            decode.results[0]   = ascii_res;
            decode.result_count = 2'd1;
         end
         decode.pending_count = 2'd0;
      end else if (byte_value <= utf8d_pkg::ContMax) begin
         if (pending_count != 2'd0) begin
            decode.code_accumulator = shifted_acc;
            decode.pending_count    = cont_left;
            if (cont_left == 2'd0) begin
               decode.results[0]   = utf8d_pkg::make_result(shifted_acc, 1'b0);
               decode.result_count = 2'd1;
            end
         end else begin
            decode.results[0]   = repl;
            decode.result_count = 2'd1;
         end
      end else if (byte_value <= utf8d_pkg::Lead2Max) begin
         decode.pending_count    = 2'd1;
         decode.code_accumulator = {{(utf8d_pkg::CpWidth-8){1'b0}},
                                    byte_value & utf8d_pkg::Lead2Mask};
      end else if (byte_value <= utf8d_pkg::Lead3Max) begin
         decode.pending_count    = 2'd2;
         decode.code_accumulator = {{(utf8d_pkg::CpWidth-8){1'b0}},
                                    byte_value & utf8d_pkg::Lead3Mask};
      end else if (byte_value <= utf8d_pkg::Lead4Max) begin
         decode.pending_count    = 2'd3;
         decode.code_accumulator = {{(utf8d_pkg::CpWidth-8){1'b0}},
                                    byte_value & utf8d_pkg::Lead4Mask};
      end else begin
         decode.results[0]    = repl;
         decode.result_count  = 2'd1;
         decode.pending_count = 2'd0;
      end

      // An unfinished sequence at end of text only arises when no result was
      // produced above, so the replacement always fits.
      if (end_of_text) begin
         if (decode.pending_count != 2'd0) begin
            decode.results[decode.result_count[0]] = repl;
            decode.result_count = decode.result_count + 2'd1;
         end
         decode.pending_count    = 2'd0;
         decode.code_accumulator = '0;
      end

      unique case (decode.result_count)
         2'd1:    decode.results[0].last_of_run = 1'b1;
         2'd2:    decode.results[1].last_of_run = 1'b1;
         default: ;
      endcase
   end

endmodule

### rtl/utf8d_result_fifo.sv
// Small result queue in flip-flops: takes zero, one or two results per cycle
// and gives out one on each pop.
module utf8d_result_fifo (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [1:0]                                    push_count,
   input  utf8d_pkg::result_type [utf8d_pkg::MaxResults-1:0] push_data,
   input  logic                                          pop,
   output utf8d_pkg::result_type                         head,
   output logic                                          not_empty,
   output logic                                          has_room
);

   utf8d_pkg::result_type                 entry_ff [utf8d_pkg::FifoDepth];
   logic [utf8d_pkg::FifoPtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [utf8d_pkg::FifoPtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [utf8d_pkg::FifoCntWidth-1:0]    count_ff, count_in;
   logic [utf8d_pkg::FifoPtrWidth-1:0]    wr_addr [utf8d_pkg::MaxResults];

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   // Room for the largest burst one byte can produce.
   assign has_room  = (count_ff <= utf8d_pkg::FifoCntWidth'(utf8d_pkg::FifoDepth
                                                           - utf8d_pkg::MaxResults));

   always_comb begin
      for (int i = 0; i < utf8d_pkg::MaxResults; i++) begin
         wr_addr[i] = wr_ptr_ff + utf8d_pkg::FifoPtrWidth'(i);
      end
      wr_ptr_in = wr_ptr_ff + utf8d_pkg::FifoPtrWidth'(push_count);
      rd_ptr_in = rd_ptr_ff + utf8d_pkg::FifoPtrWidth'(pop);
      count_in  = count_ff + utf8d_pkg::FifoCntWidth'(push_count)
                           - utf8d_pkg::FifoCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < utf8d_pkg::MaxResults; i++) begin
         if (push_count > 2'(i)) begin
            entry_ff[wr_addr[i]] <= push_data[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/utf8_byte_stream_decoder.sv
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_ready  req_byte_value[7:0], req_end_of_text
// rsp      out  rsp_valid / rsp_ready  rsp_code_point[20:0], rsp_is_replacement, rsp_last_of_run
//
// One byte is accepted per cycle while req_ready is high. An accepted request is held in the input
// register and decoded from it; once the queue has room, its results are written into a four-entry
// result queue and the decoder state updates. The first result reaches rsp through the input
// register and then the queue. The queue drains one result per cycle while rsp_ready is high, and the
// queue's free space (two entries needed) sets when req_ready drops. req_ready depends only on
// registers, never on rsp_ready. Synchronous reset empties the input register and the queue and
// clears the decoder state.
module utf8_byte_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_byte_value,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utf8d_pkg::CpWidth-1:0] rsp_code_point,
   output logic                          rsp_is_replacement,
   output logic                          rsp_last_of_run
);

   // Input register holding one accepted request.
   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    in_byte_ff;
   logic                          in_eot_ff;

   // Decoder state: continuation bytes still expected and the partial code point.
   logic [1:0]                    pending_count_ff;
   logic [utf8d_pkg::CpWidth-1:0] code_accumulator_ff;

   utf8d_pkg::decode_type         decode;
   utf8d_pkg::result_type         head;
   logic                          fifo_room;
   logic                          advance;
   logic                          req_take;
   logic [1:0]                    push_count;

   utf8d_decode u_decode (
      .byte_value       (in_byte_ff),
      .end_of_text      (in_eot_ff),
      .pending_count    (pending_count_ff),
      .code_accumulator (code_accumulator_ff),
      .decode           (decode)
   );

   // The held request moves on once the queue can absorb its worst case of two
   // results; the state updates in the same cycle, so consecutive bytes chain.
   assign advance    = in_valid_ff && fifo_room;
   assign req_ready  = !in_valid_ff || advance;
   assign req_take   = req_valid && req_ready;
   assign push_count = advance ? decode.result_count : 2'd0;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   utf8d_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (decode.results),
      .pop        (rsp_valid && rsp_ready),
      .head       (head),
      .not_empty  (rsp_valid),
      .has_room   (fifo_room)
   );

   assign rsp_code_point     = head.code_point;
   assign rsp_is_replacement = head.is_replacement;
   assign rsp_last_of_run    = head.last_of_run;

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_value;
         in_eot_ff  <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         pending_count_ff    <= 2'd0;
         code_accumulator_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pending_count_ff    <= decode.pending_count;
            code_accumulator_ff <= decode.code_accumulator;
         end
      end
   end

endmodule

### bench/utf8_byte_stream_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_byte_stream_decoder_tb;

   // Number of random bytes after the directed text, and the number of cycles
   // without any handshake on either channel that counts as a hang.
   localparam int RandomBytes = 1400;
   localparam int IdleLimit   = 3000;

   // Directed text. Bit 8 of each entry is the end-of-text flag and bits 7:0
   // are the byte. It walks through the ASCII extremes, the largest two-, three-
   // and four-byte values, a stray continuation, both ends of the invalid range,
   // an ASCII byte cutting off a sequence, a lead byte silently dropping a
   // pending sequence, an invalid byte inside a sequence, and sequences left
   // unfinished at the end of a string.
   localparam logic [8:0] DirectedText [25] = '{
      9'h000, 9'h17F,                   // NUL, then DEL closing a string
      9'h0DF, 9'h0BF,                   // U+7FF
      9'h0EF, 9'h0BF, 9'h0BF,           // U+FFFF
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // U+1FFFFF, top of the 21-bit range
      9'h080,                           // continuation with nothing pending
      9'h0FF, 9'h0F8,                   // invalid bytes
      9'h0E2, 9'h041,                   // 'A' cuts off a three-byte sequence
      9'h0C3, 9'h0E2, 9'h082, 9'h0AC,   // new lead drops the pending one, U+20AC
      9'h0F0, 9'h0F8,                   // invalid byte inside a sequence
      9'h0E2, 9'h182,                   // string ends one byte short
      9'h1C0                            // string ends right after a lead byte
   };

   // Kinds of random text and of receiver behavior.
   typedef enum int {TextChar, TextBroken, TextStray, TextInvalid, TextNoise} text_kind_type;
   typedef enum int {SinkHold, SinkOpen, SinkBusy, SinkSlow} sink_mode_type;

   // Tracks the decoder state and holds the characters it must give out, in order.
   class decoded_char_board_type;
      utf8d_pkg::result_type         expected_chars[$];
      logic [1:0]                    conts_left;
      logic [utf8d_pkg::CpWidth-1:0] partial_cp;
      int                            errors;
      int                            bytes_seen;
      int                            chars_checked;
      int                            replacements_seen;

      function new();
         conts_left        = '0;
         partial_cp        = '0;
         errors            = 0;
         bytes_seen        = 0;
         chars_checked     = 0;
         replacements_seen = 0;
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      // Works out the characters that one accepted byte gives and queues them.
      function void decode_byte(logic [7:0] b, logic eot);
         utf8d_pkg::result_type out [2];
         int                    n;
         n = 0;
         bytes_seen++;
         if (b <= utf8d_pkg::AsciiMax) begin
            if (conts_left != 0) begin
               out[n] = utf8d_pkg::make_result(utf8d_pkg::ReplacementCp, 1'b1);
               n++;
               conts_left = '0;
            end
            out[n] = utf8d_pkg::make_result(utf8d_pkg::CpWidth'(b), 1'b0);
            n++;
         end else if (b <= utf8d_pkg::ContMax) begin
            if (conts_left != 0) begin
               partial_cp = {partial_cp[utf8d_pkg::CpWidth-7:0], b[5:0]};
               conts_left = conts_left - 2'd1;
               if (conts_left == 0) begin
                  out[n] = utf8d_pkg::make_result(partial_cp, 1'b0);
                  n++;
               end
            end else begin
               out[n] = utf8d_pkg::make_result(utf8d_pkg::ReplacementCp, 1'b1);
               n++;
            end
         end else if (b <= utf8d_pkg::Lead2Max) begin
            conts_left = 2'd1;
            partial_cp = utf8d_pkg::CpWidth'(b & utf8d_pkg::Lead2Mask);
         end else if (b <= utf8d_pkg::Lead3Max) begin
            conts_left = 2'd2;
            partial_cp = utf8d_pkg::CpWidth'(b & utf8d_pkg::Lead3Mask);
         end else if (b <= utf8d_pkg::Lead4Max) begin
            conts_left = 2'd3;
            partial_cp = utf8d_pkg::CpWidth'(b & utf8d_pkg::Lead4Mask);
         end else begin
            out[n] = utf8d_pkg::make_result(utf8d_pkg::ReplacementCp, 1'b1);
            n++;
            conts_left = '0;
         end

         // A string that ends inside a sequence gets one more replacement, and
         // the next string always starts from a clean state.
         if (eot) begin
            if (conts_left != 0) begin
               out[n] = utf8d_pkg::make_result(utf8d_pkg::ReplacementCp, 1'b1);
               n++;
            end
            conts_left = '0;
            partial_cp = '0;
         end

         if (n > 0) out[n-1].last_of_run = 1'b1;
         for (int k = 0; k < n; k++) expected_chars = {expected_chars, out[k]};
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH: %s", msg);
      endtask

      task check_char(logic [utf8d_pkg::CpWidth-1:0] cp, logic repl, logic last);
         utf8d_pkg::result_type want;
         chars_checked++;
         if (repl) replacements_seen++;
         if (expected_chars.size() == 0) begin
            report($sformatf("result %0d: U+%06h arrived with nothing outstanding",
                             chars_checked, cp));
         end else begin
            want = expected_chars.pop_front();
            if (cp !== want.code_point)
               report($sformatf("result %0d: code point %06h, expected %06h",
                                chars_checked, cp, want.code_point));
            if (repl !== want.is_replacement)
               report($sformatf("result %0d: replacement flag %b, expected %b",
                                chars_checked, repl, want.is_replacement));
            if (last !== want.last_of_run)
               report($sformatf("result %0d: last-of-run flag %b, expected %b",
                                chars_checked, last, want.last_of_run));
         end
      endtask
   endclass

   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_byte_value  = '0;
   logic                          req_end_of_text = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [utf8d_pkg::CpWidth-1:0] rsp_code_point;
   logic                          rsp_is_replacement;
   logic                          rsp_last_of_run;

   decoded_char_board_type board = new();

   // Request text, filled before driving starts.
   logic [7:0] text_bytes[$];
   logic       text_ends[$];

   // Set by the sender when the random text begins; the receiver then does
   // its one guaranteed long hold-off.
   bit random_phase = 1'b0;
   bit held_once    = 1'b0;
   int longest_hold = 0;
   int idle_cycles  = 0;

   utf8_byte_stream_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_value     (req_byte_value),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   function void add_byte(logic [7:0] b, logic eot);
      text_bytes = {text_bytes, b};
      text_ends  = {text_ends, eot};
   endfunction

   // Every accepted result is checked against the oldest outstanding character.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_char(rsp_code_point, rsp_is_replacement, rsp_last_of_run);
   end

   // Hang detection: any handshake on either channel restarts the count. A
   // result that never arrives leaves both channels silent and ends up here.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     IdleLimit, board.outstanding());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Receiver. It alternates between segments where it is always ready,
   // mostly ready, ready less than half the time, or fully stalled. Once the random text has
   // started it does one long hold-off so that the result queue fills and the
   // block has to drop req_ready while the sender keeps offering bytes.
   initial begin : result_sink
      sink_mode_type mode;
      int            seg_len;
      int            pick;
      while (reset) @(posedge clock);
      forever begin
         if (random_phase && !held_once) begin
            seg_len = $urandom_range(150, 220);
            held_once = 1'b1;
            if (seg_len > longest_hold) longest_hold = seg_len;
            rsp_ready <= 1'b0;
            repeat (seg_len) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 11);
            if (pick == 0)     mode = SinkHold;
            else if (pick < 5) mode = SinkOpen;
            else if (pick < 9) mode = SinkBusy;
            else               mode = SinkSlow;
            if (mode == SinkHold) begin
               seg_len = $urandom_range(20, 70);
               if (seg_len > longest_hold) longest_hold = seg_len;
               rsp_ready <= 1'b0;
               repeat (seg_len) @(posedge clock);
            end else begin
               seg_len = $urandom_range(4, 40);
               repeat (seg_len) begin
                  case (mode)
                     SinkOpen: rsp_ready <= 1'b1;
                     SinkBusy: rsp_ready <= ($urandom_range(0, 3) != 0);
                     default:  rsp_ready <= ($urandom_range(0, 4) < 2);
                  endcase
                  @(posedge clock);
               end
            end
         end
      end
   end

   initial begin : main_flow
      text_kind_type kind;
      int            pick;
      int            len;
      int            cut;
      int            gap;
      int            burst_left;
      int            directed_total;
      int            halfway;
      logic          eot;
      logic [31:0]   rnd;

      foreach (DirectedText[k]) add_byte(DirectedText[k][7:0], DirectedText[k][8]);
      directed_total = text_bytes.size();
      halfway        = directed_total + RandomBytes / 2;

      // Random text: mostly well-formed characters of every length with random
      // payload bits, the rest broken sequences, stray continuations, invalid
      // bytes and raw noise. End-of-text lands on the last byte of a piece.
      while (text_bytes.size() < directed_total + RandomBytes) begin
         pick = $urandom_range(0, 15);
         if (pick < 10)      kind = TextChar;
         else if (pick < 12) kind = TextBroken;
         else if (pick < 13) kind = TextStray;
         else if (pick < 14) kind = TextInvalid;
         else                kind = TextNoise;
         eot = ($urandom_range(0, 7) == 0);
         rnd = $urandom;
         case (kind)
            TextChar: begin
               len = $urandom_range(1, 4);
               case (len)
                  1: add_byte({1'b0, rnd[6:0]}, eot);
                  2: begin
                     add_byte({3'b110, rnd[4:0]}, 1'b0);
                     add_byte({2'b10, rnd[10:5]}, eot);
                  end
                  3: begin
                     add_byte({4'b1110, rnd[3:0]}, 1'b0);
                     add_byte({2'b10, rnd[9:4]}, 1'b0);
                     add_byte({2'b10, rnd[15:10]}, eot);
                  end
                  default: begin
                     add_byte({5'b11110, rnd[2:0]}, 1'b0);
                     add_byte({2'b10, rnd[8:3]}, 1'b0);
                     add_byte({2'b10, rnd[14:9]}, 1'b0);
                     add_byte({2'b10, rnd[20:15]}, eot);
                  end
               endcase
            end
            TextBroken: begin
               // A lead byte followed by too few continuations; the end of the string or any
               // following byte that is not a continuation breaks it off.
               len = $urandom_range(2, 4);
               cut = $urandom_range(0, len - 2);
               case (len)
                  2:       add_byte({3'b110, rnd[4:0]}, (cut == 0) ? eot : 1'b0);
                  3:       add_byte({4'b1110, rnd[3:0]}, (cut == 0) ? eot : 1'b0);
                  default: add_byte({5'b11110, rnd[2:0]}, (cut == 0) ? eot : 1'b0);
               endcase
               for (int k = 1; k <= cut; k++)
                  add_byte({2'b10, rnd[6*k+5 -: 6]}, (k == cut) ? eot : 1'b0);
            end
            TextStray:   add_byte({2'b10, rnd[5:0]}, eot);
            TextInvalid: add_byte({5'b11111, rnd[2:0]}, eot);
            default:     add_byte(rnd[7:0], eot);
         endcase
      end

      while (reset) @(posedge clock);

      // Sender: bursts of random length separated by random gaps. Before the
      // random text and again halfway through it, the sender stops and waits
      // until every outstanding character has come out.
      burst_left = 0;
      for (int i = 0; i < text_bytes.size(); i++) begin
         if (i == directed_total || i == halfway) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.outstanding() != 0) @(posedge clock);
            random_phase = 1'b1;
            burst_left = $urandom_range(8, 40);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_byte_value  <= text_bytes[i];
         req_end_of_text <= text_ends[i];
         req_valid       <= 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         board.decode_byte(text_bytes[i], text_ends[i]);
      end
      req_valid <= 1'b0;

      // Let everything drain, then give the block a few more cycles in case
      // it produces anything it should not.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d bytes (%0d directed), checked %0d characters, %0d replacements.",
               board.bytes_seen, directed_total, board.chars_checked,
               board.replacements_seen);
      $display("Longest receiver stall %0d cycles; mismatches %0d.",
               longest_hold, board.errors);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_result_fifo.sv
rtl/utf8_byte_stream_decoder.sv
bench/utf8_byte_stream_decoder_tb.sv
